// ===== hw/rtl/humidity_frame_crc_decoder_assert.svh =====
// Assertion macros shared by the checker of the humidity frame decoder.
// Depends on nothing; included by the checker file only.
`ifndef HUMIDITY_FRAME_CRC_DECODER_ASSERT_SVH
`define HUMIDITY_FRAME_CRC_DECODER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define HFCD_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HFCD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hfcd_pkg.sv =====
// Package of the humidity frame decoder: types, constants and the CRC-8 step.
// Depends on nothing; used by the frame tracker, the scaler and the top level.
package hfcd_pkg;

    // CRC-8 with polynomial 0x31, initial value 0xFF, MSB first.
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Conversion constants for hundredths of a degree and of a percent.
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;

    // Position of a byte within the six-byte reply.
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } byte_pos_t;

    // What the frame tracker hands to the converter when a reply completes.
    typedef struct packed {
        logic        done;
        logic        good;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } frame_result_t;

    // One byte of CRC-8, eight shift steps unrolled.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        begin
            c = crc ^ data;
            for (int i = 0; i < 8; i++) begin
                if (c[7]) begin
                    c = {c[6:0], 1'b0} ^ CRC_POLY;
                end else begin
                    c = {c[6:0], 1'b0};
                end
            end
            return c;
        end
    endfunction

endpackage

// ===== hw/rtl/hfcd_frame_track.sv =====
// Byte position tracking, CRC checking and word assembly for one sensor reply.
// Depends on hfcd_pkg for the position type, the result struct and crc8_step.
module hfcd_frame_track (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  frame_start,
    output hfcd_pkg::frame_result_t frame
);

    hfcd_pkg::byte_pos_t pos_reg, pos_next, pos_eff;
    logic [7:0]  check_reg, check_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic        first_good_reg, first_good_next;
    logic        done;
    logic        good;

    // A start flag forces the byte to be taken as the first of a reply.
    always_comb begin
        pos_eff = pos_reg;
        if (frame_start) begin
            pos_eff = hfcd_pkg::POS_T_HI;
        end
    end

    // Next byte position; unused codes behave as the first position.
    always_comb begin
        case (pos_eff)
            hfcd_pkg::POS_T_HI:  pos_next = hfcd_pkg::POS_T_LO;
            hfcd_pkg::POS_T_LO:  pos_next = hfcd_pkg::POS_T_CRC;
            hfcd_pkg::POS_T_CRC: pos_next = hfcd_pkg::POS_H_HI;
            hfcd_pkg::POS_H_HI:  pos_next = hfcd_pkg::POS_H_LO;
            hfcd_pkg::POS_H_LO:  pos_next = hfcd_pkg::POS_H_CRC;
            hfcd_pkg::POS_H_CRC: pos_next = hfcd_pkg::POS_T_HI;
            default:             pos_next = hfcd_pkg::POS_T_LO;
        endcase
    end

    // Running CRC, word capture and the result of the temperature check.
    always_comb begin
        check_next      = check_reg;
        temp_next       = temp_reg;
        hum_next        = hum_reg;
        first_good_next = first_good_reg;
        done            = 1'b0;
        good            = first_good_reg && (check_reg == data_byte);
        case (pos_eff)
            hfcd_pkg::POS_T_HI: begin
                check_next = hfcd_pkg::crc8_step(hfcd_pkg::CRC_INIT, data_byte);
                temp_next  = {data_byte, 8'h00};
            end
            hfcd_pkg::POS_T_LO: begin
                check_next = hfcd_pkg::crc8_step(check_reg, data_byte);
                temp_next  = {temp_reg[15:8], data_byte};
            end
            hfcd_pkg::POS_T_CRC: begin
                first_good_next = (check_reg == data_byte);
                check_next      = hfcd_pkg::CRC_INIT;
            end
            hfcd_pkg::POS_H_HI: begin
                check_next = hfcd_pkg::crc8_step(hfcd_pkg::CRC_INIT, data_byte);
                hum_next   = {data_byte, 8'h00};
            end
            hfcd_pkg::POS_H_LO: begin
                check_next = hfcd_pkg::crc8_step(check_reg, data_byte);
                hum_next   = {hum_reg[15:8], data_byte};
            end
            hfcd_pkg::POS_H_CRC: begin
                check_next = hfcd_pkg::CRC_INIT;
                done       = 1'b1;
            end
            default: begin
                check_next = hfcd_pkg::crc8_step(hfcd_pkg::CRC_INIT, data_byte);
                temp_next  = {data_byte, 8'h00};
            end
        endcase
    end

    // State registers advance only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= hfcd_pkg::POS_T_HI;
            check_reg      <= hfcd_pkg::CRC_INIT;
            temp_reg       <= 16'h0000;
            hum_reg        <= 16'h0000;
            first_good_reg <= 1'b0;
        end else if (accept) begin
            pos_reg        <= pos_next;
            check_reg      <= check_next;
            temp_reg       <= temp_next;
            hum_reg        <= hum_next;
            first_good_reg <= first_good_next;
        end
    end

    // Both words are complete by the time the last byte arrives.
    assign frame.done      = accept && done;
    assign frame.good      = good;
    assign frame.temp_word = temp_reg;
    assign frame.hum_word  = hum_reg;

endmodule

// ===== hw/rtl/hfcd_scale.sv =====
// Conversion of the raw sensor words into hundredths of a degree and a percent.
// Depends on hfcd_pkg for the scale and offset constants.
module hfcd_scale (
    input  logic [15:0]        temp_word,
    input  logic [15:0]        hum_word,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi
);

    logic [30:0] temp_prod;
    logic [29:0] hum_prod;
    logic [14:0] temp_floor;

    // Temperature: floor(17500 * t / 65536) - 4500, which always fits 15 bits.
    assign temp_prod  = {16'h0000, hfcd_pkg::TEMP_SCALE} * {15'h0000, temp_word};
    assign temp_floor = temp_prod[30:16];
    assign temperature_centi = signed'(temp_floor - hfcd_pkg::TEMP_OFFSET);

    // Humidity: floor(10000 * rh / 65536).
    assign hum_prod       = {16'h0000, hfcd_pkg::HUM_SCALE} * {14'h0000, hum_word};
    assign humidity_centi = hum_prod[29:16];

endmodule

// ===== hw/rtl/humidity_frame_crc_decoder.sv =====
// Sensor reply decoder: six bytes in, one status and two converted values out.
// The result is registered and appears in the cycle after the sixth byte is accepted.
// Throughput: one byte per cycle; the single result register holds s_ready low while held, frees it when taken.
// Reset: synchronous, active low; clears the byte position, CRC and result valid.
// Depends on hfcd_pkg, hfcd_frame_track and hfcd_scale.
module humidity_frame_crc_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic signed [14:0] m_temperature_centi,
    output logic [13:0]        m_humidity_centi
);

    hfcd_pkg::frame_result_t frame;
    logic               accept;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic               valid_reg;
    logic               status_reg;
    logic signed [14:0] temp_reg;
    logic [13:0]        hum_reg;

    // A new word is taken whenever the result register is empty or being drained.
    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    hfcd_frame_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .frame_start (s_frame_start),
        .frame       (frame)
    );

    hfcd_scale u_scale (
        .temp_word         (frame.temp_word),
        .hum_word          (frame.hum_word),
        .temperature_centi (temp_centi),
        .humidity_centi    (hum_centi)
    );

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= frame.done;
        end
    end

    // Result payload is loaded when a reply completes.
    always_ff @(posedge aclk) begin
        if (frame.done) begin
            status_reg <= !frame.good;
            temp_reg   <= temp_centi;
            hum_reg    <= hum_centi;
        end
    end

    assign m_valid             = valid_reg;
    assign m_status            = status_reg;
    assign m_temperature_centi = temp_reg;
    assign m_humidity_centi    = hum_reg;

endmodule

// ===== hw/rtl/hfcd_checker.sv =====
// Port-level checker for the humidity frame decoder, bound to the top level.
// Depends on humidity_frame_crc_decoder_assert.svh for the assertion macros.
`include "humidity_frame_crc_decoder_assert.svh"

module hfcd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [7:0]         s_data_byte,
    input logic               s_frame_start,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_status,
    input logic signed [14:0] m_temperature_centi,
    input logic [13:0]        m_humidity_centi
);

    // No result is offered in the cycle after reset.
    `HFCD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A held result keeps its payload.
    `HFCD_ASSERT(a_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_temperature_centi) && $stable(m_humidity_centi),
        "stalled result changed")

    // A new result only follows an accepted input word.
    `HFCD_ASSERT(a_cause, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready),
        "result without input word")

    // The input side is open whenever no result is waiting.
    `HFCD_ASSERT(a_ready, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty output")

    // Converted values stay within the sensor range.
    `HFCD_ASSERT(a_range, aclk, aresetn,
        m_valid |-> (m_temperature_centi >= -15'sd4500)
            && (m_temperature_centi <= 15'sd12999) && (m_humidity_centi <= 14'd9999),
        "value out of range")

endmodule

bind humidity_frame_crc_decoder hfcd_checker u_hfcd_checker (.*);
